// File: rtl/dts_pkg.sv
// Shared types and constants for the drag/thrust body integrator.
// No dependencies; imported by drag_thrust_body_step, dts_cordic and the testbench.
package dts_pkg;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 184;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int IO_VALUE_W  = 32;
	localparam int HEADING_W   = 16;

	// The drag, density, thrust and inverse-mass registers hold Q8.16 values
	localparam int CFG_FRAC = 16;
	// k*rho is Q.32; dropping 17 bits gives k*rho/2 in Q.16
	localparam int KR_SHIFT = 17;
	localparam int KR_W     = 31;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DRAG_COEF   = 3'd0,
		REG_AIR_DENSITY = 3'd1,
		REG_THRUST      = 3'd2,
		REG_INV_MASS    = 3'd3,
		REG_X_LIMIT     = 3'd4,
		REG_Y_LIMIT     = 3'd5
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SQX, S_SQY, S_SQRT, S_KR, S_T, S_DRX, S_DRY, S_DV, S_KEY,
		S_AX, S_BX, S_AY, S_BY, S_PX, S_PY, S_BNC, S_DLT, S_MX, S_MY,
		S_VX, S_VY, S_SQ2, S_CWAIT, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		C_IDLE, C_NORM, C_ROT
	} cord_phase_t;

	// CORDIC works on 64-bit vectors normalized into [2^59, 2^60)
	localparam int CORD_W       = 64;
	localparam int CORD_TAB_LEN = 24;
	localparam logic signed [CORD_W-1:0] CORD_TOP = 64'sd1152921504606846976;
	localparam logic signed [CORD_W-1:0] CORD_LOW = 64'sd576460752303423488;

	// Angles in 2^-16 degree
	localparam logic signed [31:0] DEG180        = 32'sd11796480;
	localparam logic signed [31:0] HEADING_ROUND = 32'sd256;
	localparam int                 HEADING_SHIFT = 9;
	localparam logic signed [31:0] HEADING_MAX   = 32'sd23040;

	localparam logic [21:0] ATAN_TAB [CORD_TAB_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

endpackage

// File: rtl/drag_thrust_body_step.sv
// Drag/thrust body integrator top level: one body tick per input word.
// Depends on dts_pkg, dts_mul, dts_sqrt and dts_cordic.
//
// Use:
//   s_* carries one tick word (keys, external force, time step). The block
//   works on one tick at a time; s_tready is high only while it is idle.
//   m_* carries the result word (new position, velocity, speed, heading and
//   wall-hit flags). The result sits in an output register, so the next tick
//   word is taken while an earlier result still waits for m_tready.
//   cfg_* writes one configuration register per handshake; cfg_ready is
//   always high. Write registers only while no tick is in flight.
// Sequence:
//   All products go through one bit-serial multiplier of MW bits
//   (MW = max(VALUE_WIDTH+1, 32)); a tick uses 17 products and two square
//   roots, plus six further steps (accept, keys, bounce, deltas, heading
//   pickup, hand-over). The CORDIC heading runs beside the final speed
//   computation and finishes before the second root does.
// Reset:
//   arst_n clears position, velocity and heading to zero and loads the
//   register defaults (unit density and inverse mass, no drag or thrust,
//   walls at the top of the range). A stalled receiver holds the result
//   word; the block then finishes the next tick and waits to hand it over.
module drag_thrust_body_step #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	// tdata: key_left[0], key_right[1], key_up[2], key_down[3], force_x[35:4],
	//        force_y[67:36], time_step[83:68], zero pad[87:84]
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dts_pkg::IN_TDATA_W-1:0]     s_tdata,
	// tdata: position_x[31:0], position_y[63:32], velocity_x[95:64],
	//        velocity_y[127:96], speed_magnitude[159:128], heading[175:160],
	//        bounced[177:176], zero pad[183:178]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dts_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dts_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dts_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dts_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int MW = (W + 1 > 32) ? W + 1 : 32;
	localparam int PW = 2 * MW;
	localparam int DV_SHIFT = 2 * CFG_FRAC - F;
	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [65:0]  DLIM = 66'sd4611686018427387904;
	localparam longint unsigned MOVE_LIM = (64'd1 << (2 * F)) / 64'd1000000;

	// ---------------------------------------------------------------- helpers
	function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? VMIN : VMAX;
		end
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? VMIN : VMAX;
		end
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] nsat(input logic signed [W-1:0] a);
		return (a == VMIN) ? VMAX : -a;
	endfunction

	function automatic logic [MW-1:0] mag_w(input logic signed [W-1:0] a);
		logic [W:0] e;
		e = {a[W-1], a};
		if (a[W-1]) begin
			e = -e;
		end
		return MW'(e);
	endfunction

	// Saturate a shifted product magnitude and apply the sign
	function automatic logic signed [W-1:0] shsat(input logic [PW-1:0] m,
			input logic neg);
		logic signed [W-1:0] r;
		r = W'(m);
		if (m > {{(PW-W){1'b0}}, VMAX}) begin
			return neg ? VMIN : VMAX;
		end
		return neg ? -r : r;
	endfunction

	function automatic logic signed [W-1:0] clamp_in(input logic signed [31:0] v);
		logic signed [65:0] e;
		e = 66'(v);
		if (e > 66'(VMAX)) begin
			return VMAX;
		end
		if (e < 66'(VMIN)) begin
			return VMIN;
		end
		return W'(e);
	endfunction

	function automatic logic signed [W-1:0] lim_w(input logic [KR_W-1:0] l);
		logic [65:0] e;
		e = {{(66-KR_W){1'b0}}, l};
		if (e > 66'(VMAX)) begin
			return VMAX;
		end
		return W'(e);
	endfunction

	function automatic logic signed [W-1:0] keys_on(input logic signed [W-1:0] v,
			input logic dn, input logic up, input logic signed [W-1:0] d);
		logic signed [W-1:0] r;
		r = dn ? ssub(v, d) : v;
		return up ? sadd(r, d) : r;
	endfunction

	// Position change, clamped to +-2^62
	function automatic logic signed [CORD_W-1:0] delta(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [65:0] d;
		d = 66'(a) - 66'(b);
		if (d > DLIM) begin
			d = DLIM;
		end else if (d < -DLIM) begin
			d = -DLIM;
		end
		return CORD_W'(d);
	endfunction

	function automatic logic [MW-1:0] mag_d(input logic signed [CORD_W-1:0] a);
		logic [CORD_W-1:0] e;
		e = a[CORD_W-1] ? -a : a;
		return MW'(e);
	endfunction

	// ---------------------------------------------------------------- state
	state_t state_q, state_d;
	logic   launch_q;

	logic [23:0]       drag_q, rho_q, thrust_q, invm_q;
	logic [KR_W-1:0]   xlim_q, ylim_q;

	logic signed [W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic signed [HEADING_W-1:0] heading_q;

	logic [3:0]          keys_q;
	logic signed [W-1:0] fx_q, fy_q, opx_q, opy_q, t_q, dragx_q, dragy_q, dv_q, acc_q;
	logic [15:0]         dt_q;
	logic [PW-1:0]       sqa_q;
	logic [PW:0]         sum_q;
	logic [W-1:0]        s_q, speed_q;
	logic [KR_W-1:0]     kr_q;
	logic [1:0]          hit_q;
	logic signed [CORD_W-1:0] dx_q, dy_q;
	logic                moved_q;
	logic                m_tvalid_q;
	logic [OUT_TDATA_W-1:0] out_q;

	logic signed [W-1:0] lx, ly;

	// shared units
	logic          mul_go, mul_busy, mul_done;
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] mul_prod;
	logic          sq_go, sq_done;
	logic [W-1:0]  sq_root;
	logic          cord_go, cord_busy;
	logic signed [HEADING_W-1:0] cord_heading;

	dts_mul #(.MW(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .done(mul_done), .prod(mul_prod)
	);

	dts_sqrt #(.RW(W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go), .radicand(sum_q[2*W-1:0]),
		.done(sq_done), .root(sq_root)
	);

	dts_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_go), .x_in(dx_q), .y_in(dy_q),
		.busy(cord_busy), .heading(cord_heading)
	);

	assign lx = lim_w(xlim_q);
	assign ly = lim_w(ylim_q);

	// ---------------------------------------------------------------- sequencer
	// Each arithmetic state launches its unit on entry and advances on done.
	always_comb begin
		state_d = state_q;
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		sq_go   = 1'b0;
		cord_go = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_SQX;
				end
			end
			S_SQX: begin
				mul_go = launch_q;
				mul_a  = mag_w(vel_x_q);
				mul_b  = mag_w(vel_x_q);
				if (mul_done) state_d = S_SQY;
			end
			S_SQY: begin
				mul_go = launch_q;
				mul_a  = mag_w(vel_y_q);
				mul_b  = mag_w(vel_y_q);
				if (mul_done) state_d = S_SQRT;
			end
			S_SQRT: begin
				sq_go = launch_q;
				if (sq_done) state_d = S_KR;
			end
			S_KR: begin
				mul_go = launch_q;
				mul_a  = MW'(drag_q);
				mul_b  = MW'(rho_q);
				if (mul_done) state_d = S_T;
			end
			S_T: begin
				mul_go = launch_q;
				mul_a  = MW'(kr_q);
				mul_b  = MW'(s_q);
				if (mul_done) state_d = S_DRX;
			end
			S_DRX: begin
				mul_go = launch_q;
				mul_a  = mag_w(vel_x_q);
				mul_b  = mag_w(t_q);
				if (mul_done) state_d = S_DRY;
			end
			S_DRY: begin
				mul_go = launch_q;
				mul_a  = mag_w(vel_y_q);
				mul_b  = mag_w(t_q);
				if (mul_done) state_d = S_DV;
			end
			S_DV: begin
				mul_go = launch_q;
				mul_a  = MW'(thrust_q);
				mul_b  = MW'(dt_q);
				if (mul_done) state_d = S_KEY;
			end
			S_KEY: state_d = S_AX;
			S_AX: begin
				mul_go = launch_q;
				mul_a  = mag_w(fx_q);
				mul_b  = MW'(invm_q);
				if (mul_done) state_d = S_BX;
			end
			S_BX: begin
				mul_go = launch_q;
				mul_a  = mag_w(acc_q);
				mul_b  = MW'(dt_q);
				if (mul_done) state_d = S_AY;
			end
			S_AY: begin
				mul_go = launch_q;
				mul_a  = mag_w(fy_q);
				mul_b  = MW'(invm_q);
				if (mul_done) state_d = S_BY;
			end
			S_BY: begin
				mul_go = launch_q;
				mul_a  = mag_w(acc_q);
				mul_b  = MW'(dt_q);
				if (mul_done) state_d = S_PX;
			end
			S_PX: begin
				mul_go = launch_q;
				mul_a  = mag_w(vel_x_q);
				mul_b  = MW'(dt_q);
				if (mul_done) state_d = S_PY;
			end
			S_PY: begin
				mul_go = launch_q;
				mul_a  = mag_w(vel_y_q);
				mul_b  = MW'(dt_q);
				if (mul_done) state_d = S_BNC;
			end
			S_BNC: state_d = S_DLT;
			S_DLT: state_d = S_MX;
			S_MX: begin
				mul_go = launch_q;
				mul_a  = mag_d(dx_q);
				mul_b  = mag_d(dx_q);
				if (mul_done) state_d = S_MY;
			end
			S_MY: begin
				mul_go = launch_q;
				mul_a  = mag_d(dy_q);
				mul_b  = mag_d(dy_q);
				if (mul_done) state_d = S_VX;
			end
			S_VX: begin
				// heading search runs beside the speed computation
				cord_go = launch_q && moved_q;
				mul_go  = launch_q;
				mul_a   = mag_w(vel_x_q);
				mul_b   = mag_w(vel_x_q);
				if (mul_done) state_d = S_VY;
			end
			S_VY: begin
				mul_go = launch_q;
				mul_a  = mag_w(vel_y_q);
				mul_b  = mag_w(vel_y_q);
				if (mul_done) state_d = S_SQ2;
			end
			S_SQ2: begin
				sq_go = launch_q;
				if (sq_done) state_d = S_CWAIT;
			end
			S_CWAIT: begin
				if (!cord_busy) state_d = S_DONE;
			end
			S_DONE: begin
				// hold the finished tick until the output register frees up
				if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launch_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q);
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- body state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q    <= 24'd0;
			rho_q     <= 24'd65536;
			thrust_q  <= 24'd0;
			invm_q    <= 24'd65536;
			xlim_q    <= {KR_W{1'b1}};
			ylim_q    <= {KR_W{1'b1}};
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			vel_x_q   <= '0;
			vel_y_q   <= '0;
			heading_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_DRAG_COEF:   drag_q   <= cfg_data[23:0];
					REG_AIR_DENSITY: rho_q    <= cfg_data[23:0];
					REG_THRUST:      thrust_q <= cfg_data[23:0];
					REG_INV_MASS:    invm_q   <= cfg_data[23:0];
					REG_X_LIMIT:     xlim_q   <= cfg_data[KR_W-1:0];
					REG_Y_LIMIT:     ylim_q   <= cfg_data[KR_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_KEY: begin
					// opposite keys cancel: subtract first, then add
					vel_x_q <= keys_on(vel_x_q, keys_q[0], keys_q[1], dv_q);
					vel_y_q <= keys_on(vel_y_q, keys_q[2], keys_q[3], dv_q);
				end
				S_BX: if (mul_done) vel_x_q <= sadd(vel_x_q, shsat(mul_prod >> CFG_FRAC, acc_q[W-1]));
				S_BY: if (mul_done) vel_y_q <= sadd(vel_y_q, shsat(mul_prod >> CFG_FRAC, acc_q[W-1]));
				S_PX: if (mul_done) pos_x_q <= sadd(pos_x_q, shsat(mul_prod >> CFG_FRAC, vel_x_q[W-1]));
				S_PY: if (mul_done) pos_y_q <= sadd(pos_y_q, shsat(mul_prod >> CFG_FRAC, vel_y_q[W-1]));
				S_BNC: begin
					// mirror once about the crossed wall and reverse that axis
					if (pos_x_q > lx) begin
						pos_x_q <= sadd(ssub(lx, pos_x_q), lx);
						vel_x_q <= nsat(vel_x_q);
					end else if (pos_x_q < -lx) begin
						pos_x_q <= sadd(ssub(-lx, pos_x_q), -lx);
						vel_x_q <= nsat(vel_x_q);
					end
					if (pos_y_q > ly) begin
						pos_y_q <= sadd(ssub(ly, pos_y_q), ly);
						vel_y_q <= nsat(vel_y_q);
					end else if (pos_y_q < -ly) begin
						pos_y_q <= sadd(ssub(-ly, pos_y_q), -ly);
						vel_y_q <= nsat(vel_y_q);
					end
				end
				S_CWAIT: if (!cord_busy && moved_q) heading_q <= cord_heading;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					keys_q <= s_tdata[3:0];
					fx_q   <= clamp_in(s_tdata[35:4]);
					fy_q   <= clamp_in(s_tdata[67:36]);
					dt_q   <= s_tdata[83:68];
					opx_q  <= pos_x_q;
					opy_q  <= pos_y_q;
				end
			end
			S_SQX, S_MX, S_VX: if (mul_done) sqa_q <= mul_prod;
			S_SQY, S_VY: if (mul_done) sum_q <= {1'b0, sqa_q} + {1'b0, mul_prod};
			S_SQRT: if (sq_done) s_q <= sq_root;
			S_KR: if (mul_done) kr_q <= mul_prod[KR_SHIFT +: KR_W];
			S_T: if (mul_done) t_q <= shsat(mul_prod >> CFG_FRAC, 1'b0);
			S_DRX: if (mul_done) dragx_q <= nsat(shsat(mul_prod >> F, vel_x_q[W-1]));
			S_DRY: if (mul_done) dragy_q <= nsat(shsat(mul_prod >> F, vel_y_q[W-1]));
			S_DV: if (mul_done) dv_q <= shsat(mul_prod >> DV_SHIFT, 1'b0);
			S_KEY: begin
				fx_q <= sadd(fx_q, dragx_q);
				fy_q <= sadd(fy_q, dragy_q);
			end
			S_AX: if (mul_done) acc_q <= shsat(mul_prod >> CFG_FRAC, fx_q[W-1]);
			S_AY: if (mul_done) acc_q <= shsat(mul_prod >> CFG_FRAC, fy_q[W-1]);
			S_BNC: begin
				hit_q <= {(pos_y_q > ly) || (pos_y_q < -ly), (pos_x_q > lx) || (pos_x_q < -lx)};
			end
			S_DLT: begin
				dx_q <= delta(pos_x_q, opx_q);
				dy_q <= delta(pos_y_q, opy_q);
			end
			S_MY: begin
				if (mul_done) begin
					moved_q <= ({1'b0, sqa_q} + {1'b0, mul_prod}) > (PW+1)'(MOVE_LIM);
				end
			end
			S_SQ2: if (sq_done) speed_q <= sq_root;
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_q <= {6'b0, hit_q, heading_q, IO_VALUE_W'(speed_q),
						IO_VALUE_W'(vel_y_q), IO_VALUE_W'(vel_x_q),
						IO_VALUE_W'(pos_y_q), IO_VALUE_W'(pos_x_q)};
				end
			end
			default: ;
		endcase
	end

	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- assertions
	a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go |-> !mul_busy)
		else $error("multiplier launched while busy");

	a_cordic_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cord_go |-> !cord_busy)
		else $error("cordic launched while busy");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && m_tvalid_q && !m_tready) |=> (state_q == S_DONE))
		else $error("result overwrote an untaken word");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[175:160]) <= 16'sd23040
			&& $signed(m_tdata[175:160]) >= -16'sd23040))
		else $error("heading out of range");

endmodule

// File: rtl/dts_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing but its parameter.
module dts_mul #(
	parameter int MW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic            busy,
	output logic            done,
	output logic [2*MW-1:0] prod
);
	localparam int CNTW = $clog2(MW);

	logic [2*MW-1:0] p_q;
	logic [MW-1:0]   a_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [MW:0]     sum;

	always_comb begin
		sum = {1'b0, p_q[2*MW-1:MW]} + (p_q[0] ? {1'b0, a_q} : {(MW+1){1'b0}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(MW-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Add the multiplicand under the low bit, shift the pair right
	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{MW{1'b0}}, b};
			a_q <= a;
		end else if (run_q) begin
			p_q <= {sum, p_q[MW-1:1]};
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign prod = p_q;

endmodule

// File: rtl/dts_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on nothing but its parameter.
module dts_sqrt #(
	parameter int RW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] radicand,
	output logic            done,
	output logic [RW-1:0]   root
);
	localparam int CNTW = $clog2(RW);

	logic [2*RW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [RW+3:0]   cur;
	logic [RW+3:0]   trial;
	logic [RW+3:0]   diff;
	logic            fits;

	always_comb begin
		cur   = {rem_q, rad_q[2*RW-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		diff  = cur - trial;
		fits  = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(RW-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= diff[RW+1:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= cur[RW+1:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/dts_cordic.sv
// Iterative CORDIC vectoring: heading of (x, y) in 1/128 degree.
// Depends on dts_pkg for the angle table and scaling constants.
module dts_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [dts_pkg::CORD_W-1:0] x_in,
	input  logic signed [dts_pkg::CORD_W-1:0] y_in,
	output logic                              busy,
	output logic signed [dts_pkg::HEADING_W-1:0] heading
);
	import dts_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS < CORD_TAB_LEN) ? CORDIC_STEPS : CORD_TAB_LEN;

	cord_phase_t phase_q, phase_d;

	logic signed [CORD_W-1:0]    x_q, y_q, xs, ys, x_n, y_n;
	logic signed [31:0]          z_q, z_n, ang, h;
	logic [4:0]                  i_q;
	logic signed [HEADING_W-1:0] heading_q;
	logic                        big, tiny, last;

	always_comb begin
		big  = (x_q >= CORD_TOP) || (y_q >= CORD_TOP) || (y_q <= -CORD_TOP);
		tiny = (x_q < CORD_LOW) && (y_q < CORD_LOW) && (y_q > -CORD_LOW);
		xs   = x_q >>> i_q;
		ys   = y_q >>> i_q;
		ang  = signed'({10'b0, ATAN_TAB[i_q]});
		if (y_q > 0) begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + ang;
		end else begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - ang;
		end
		h    = (z_n + HEADING_ROUND) >>> HEADING_SHIFT;
		last = (i_q == 5'(NSTEP-1));
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			C_IDLE: begin
				if (start && !(x_in == '0 && y_in == '0)) begin
					phase_d = C_NORM;
				end
			end
			C_NORM: begin
				if (!big && !tiny) begin
					phase_d = C_ROT;
				end
			end
			C_ROT: begin
				if (last) begin
					phase_d = C_IDLE;
				end
			end
			default: phase_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= C_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			C_IDLE: begin
				if (start) begin
					// Turn a left-half vector by 180 degrees first
					x_q <= x_in[CORD_W-1] ? -x_in : x_in;
					y_q <= x_in[CORD_W-1] ? -y_in : y_in;
					z_q <= x_in[CORD_W-1] ? (y_in[CORD_W-1] ? -DEG180 : DEG180) : '0;
					i_q <= '0;
					if (x_in == '0 && y_in == '0) begin
						heading_q <= '0;
					end
				end
			end
			C_NORM: begin
				if (big) begin
					x_q <= x_q >>> 1;
					y_q <= y_q >>> 1;
				end else if (tiny) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			C_ROT: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
				i_q <= i_q + 1'b1;
				if (last) begin
					if (h > HEADING_MAX) begin
						heading_q <= HEADING_W'(HEADING_MAX);
					end else if (h < -HEADING_MAX) begin
						heading_q <= HEADING_W'(-HEADING_MAX);
					end else begin
						heading_q <= HEADING_W'(h);
					end
				end
			end
			default: ;
		endcase
	end

	assign busy    = (phase_q != C_IDLE);
	assign heading = heading_q;

endmodule

// File: tb/tb_drag_thrust_body_step.sv
// Self-checking testbench for drag_thrust_body_step: random and directed ticks with checking.
// Depends on dts_pkg and the drag_thrust_body_step RTL; needs no other files.
module tb_drag_thrust_body_step;
	timeunit 1ns;
	timeprecision 1ps;
	import dts_pkg::*;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam int TICK_CYCLES = 700;     // settle wait at the end of drain()
	localparam int LONG_HOLD = 3000;
	localparam logic [127:0] MOVE_SQ_LIMIT = 128'd4294;   // floor(2^32 / 10^6)
	localparam longint ATAN_STEP [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic [31:0] pos_x, pos_y, vel_x, vel_y, speed;
		logic [15:0] heading;
		logic [1:0]  bounced;
	} body_state_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	drag_thrust_body_step uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Predictor copy of registers and body state
	longint drag_k, density, thrust_acc, inv_mass, wall_x, wall_y;
	longint body_px, body_py, body_vx, body_vy;
	logic [15:0] body_heading;

	body_state_t expected_bodies[$];
	int mismatches = 0, ticks_checked = 0, ticks_sent = 0;
	bit quiet = 0;       // no idling on either side
	bit hold_req = 0;    // ask the receiver for one long hold-off

	function automatic longint clip(longint v);
		return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
	endfunction

	// Signed times unsigned, magnitude truncated after the shift, saturated
	function automatic longint scale(longint a, logic [63:0] b, int sh);
		logic [63:0] m;
		logic [127:0] p;
		m = (a < 0) ? -a : a;
		p = ({64'b0, m} * {64'b0, b}) >> sh;
		if (p > VMAX) return (a < 0) ? VMIN : VMAX;
		return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic logic [63:0] vec_length(longint vx, longint vy);
		logic [127:0] n, c;
		logic [63:0] r;
		n = vx * vx + vy * vy;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = {64'b0, r | (64'd1 << b)};
			if (c * c <= n) r = r | (64'd1 << b);
		end
		return r;
	endfunction

	function automatic logic [15:0] vector_angle(longint x, longint y);
		longint z, h, xs, ys;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
			x = -x;
			y = -y;
		end
		if (x == 0 && y == 0) return 0;
		while (x >= (64'sd1 << 60) || y >= (64'sd1 << 60) || y <= -(64'sd1 << 60)) begin
			x = x >>> 1;
			y = y >>> 1;
		end
		while (x < (64'sd1 << 59) && y < (64'sd1 << 59) && y > -(64'sd1 << 59)) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_STEP[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_STEP[i];
			end
		end
		h = (z + 256) >>> 9;
		if (h > 23040) h = 23040;
		if (h < -23040) h = -23040;
		return h[15:0];
	endfunction

	// Mirror about the wall once and reverse that axis velocity
	function automatic bit wall_mirror(inout longint p, inout longint v, input longint lim);
		if (p > lim) p = clip(clip(lim - p) + lim);
		else if (p < -lim) p = clip(clip(-lim - p) - lim);
		else return 0;
		v = clip(-v);
		return 1;
	endfunction

	function automatic body_state_t advance_body(logic [IN_TDATA_W-1:0] w);
		body_state_t r;
		longint fx, fy, dt, opx, opy, px, py, vx, vy, kr, t, dragx, dragy, dv, dx, dy;
		logic [63:0] s;
		logic [1:0] hit;
		fx = longint'(signed'(w[35:4]));
		fy = longint'(signed'(w[67:36]));
		dt = w[83:68];
		opx = body_px; opy = body_py;
		px = body_px; py = body_py; vx = body_vx; vy = body_vy;
		s = vec_length(vx, vy);
		kr = (drag_k * density) >> 17;
		t = scale(kr, s, 16);
		dragx = clip(-scale(vx, t, 16));
		dragy = clip(-scale(vy, t, 16));
		dv = scale(thrust_acc, dt, 16);
		if (w[0]) vx = clip(vx - dv);
		if (w[1]) vx = clip(vx + dv);
		if (w[2]) vy = clip(vy - dv);
		if (w[3]) vy = clip(vy + dv);
		vx = clip(vx + scale(scale(clip(fx + dragx), inv_mass, 16), dt, 16));
		vy = clip(vy + scale(scale(clip(fy + dragy), inv_mass, 16), dt, 16));
		px = clip(px + scale(vx, dt, 16));
		py = clip(py + scale(vy, dt, 16));
		hit[0] = wall_mirror(px, vx, wall_x);
		hit[1] = wall_mirror(py, vy, wall_y);
		dx = px - opx;
		dy = py - opy;
		if (128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) > MOVE_SQ_LIMIT)
			body_heading = vector_angle(dx, dy);
		body_px = px; body_py = py; body_vx = vx; body_vy = vy;
		r.pos_x = px[31:0];
		r.pos_y = py[31:0];
		r.vel_x = vx[31:0];
		r.vel_y = vy[31:0];
		r.speed = 32'(vec_length(vx, vy));
		r.heading = body_heading;
		r.bounced = hit;
		return r;
	endfunction

	// Offer one tick word, with a random gap first unless quiet
	task automatic send_tick(bit [3:0] keys, logic [31:0] fx, logic [31:0] fy,
			logic [15:0] dt);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {4'b0, dt, fy, fx, keys};
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
		expected_bodies.push_back(advance_body(s_tdata));
		ticks_sent++;
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_tvalid = 0;
	endtask

	// Wait out every pending result, then let the block settle
	task automatic drain();
		end_burst();
		while (expected_bodies.size() != 0) @(negedge clk);
		repeat (TICK_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		case (idx)
			REG_DRAG_COEF:   drag_k = val[23:0];
			REG_AIR_DENSITY: density = val[23:0];
			REG_THRUST:      thrust_acc = val[23:0];
			REG_INV_MASS:    inv_mass = val[23:0];
			REG_X_LIMIT:     wall_x = val[30:0];
			REG_Y_LIMIT:     wall_y = val[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_all(logic [31:0] k, logic [31:0] rho, logic [31:0] thr,
			logic [31:0] im, logic [31:0] lx, logic [31:0] ly);
		write_reg(REG_DRAG_COEF, k);
		write_reg(REG_AIR_DENSITY, rho);
		write_reg(REG_THRUST, thr);
		write_reg(REG_INV_MASS, im);
		write_reg(REG_X_LIMIT, lx);
		write_reg(REG_Y_LIMIT, ly);
	endtask

	// Mostly modest forces, sometimes the full range
	function automatic logic [31:0] rand_force();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(signed'(17'($urandom)));
			default: return 32'(signed'(24'($urandom)));
		endcase
	endfunction

	task automatic random_ticks(int n);
		repeat (n) send_tick(4'($urandom), rand_force(), rand_force(), 16'($urandom));
	endtask

	task automatic test_defaults();
		// zero step, extremes of force and time step with keys idle, then all keys at once
		send_tick(4'h0, 32'h0, 32'h0, 16'h0);
		send_tick(4'h0, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
		send_tick(4'h0, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
		send_tick(4'h0, 32'hFFFFFFFF, 32'h00000001, 16'h0001);
		send_tick(4'hF, 32'h0, 32'h0, 16'h8000);
		drain();
	endtask

	task automatic test_thrust_keys();
		set_all(0, 32'h10000, 32'hFFFFFF, 32'h10000, 32'h7FFFFFFF, 32'h7FFFFFFF);
		// each key alone, opposing pairs cancel, all four, then left with down
		send_tick(4'b0001, 0, 0, 16'h1000);
		send_tick(4'b0010, 0, 0, 16'h1000);
		send_tick(4'b0100, 0, 0, 16'h1000);
		send_tick(4'b1000, 0, 0, 16'h1000);
		send_tick(4'b0011, 0, 0, 16'hFFFF);
		send_tick(4'b1100, 0, 0, 16'hFFFF);
		send_tick(4'b1111, 0, 0, 16'hFFFF);
		send_tick(4'b1001, 0, 0, 16'hFFFF);
		// minimal force and time step while the body keeps its keyed velocity
		send_tick(4'b0000, 32'h1, 32'h0, 16'h1);
		drain();
	endtask

	task automatic test_drag();
		set_all(32'hFFFFFF, 32'hFFFFFF, 32'h20000, 32'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_tick(4'b0010, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
		send_tick(4'b0000, 32'h0, 32'h0, 16'hFFFF);
		send_tick(4'b0101, 32'h80000000, 32'h0, 16'h4000);
		drain();
		set_all(32'h8000, 32'h10000, 32'h10000, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF);
		random_ticks(20);
		drain();
	endtask

	task automatic test_walls();
		// walls at zero and close in so every tick mirrors
		set_all(32'h4000, 32'h10000, 32'h40000, 32'h10000, 32'h0, 32'h0);
		send_tick(4'b0010, 32'h10000, 32'hFFFF0000, 16'h8000);
		send_tick(4'b0101, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
		drain();
		set_all(32'h1000, 32'h10000, 32'h80000, 32'h10000, 32'hA0000, 32'h60000);
		random_ticks(120);
		drain();
	endtask

	task automatic test_backpressure();
		// receiver stalls long while ticks keep coming
		hold_req = 1;
		random_ticks(6);
		drain();
		random_ticks(4);
		drain();
	endtask

	task automatic test_random();
		set_all($urandom, $urandom, $urandom_range(0, 32'h40000), $urandom_range(0, 32'h30000),
			$urandom_range(32'h10000, 32'h2000000), $urandom_range(32'h10000, 32'h2000000));
		random_ticks(120);
		drain();
		set_all(32'h2000, 32'h18000, 32'h30000, 32'h8000, 32'h7FFFFFFF, 32'h3FFFFFF);
		random_ticks(120);
		drain();
		quiet = 1;
		set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		random_ticks(80);
		drain();
	endtask

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 0;
				hold_req = 0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (quiet) begin
				m_tready = 1;
			end else if ($urandom_range(0, 4) == 0) begin
				m_tready = 0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				m_tready = 1;
			end else begin
				m_tready = 1;
			end
		end
	end

	// Compare every result word with the oldest prediction
	always @(posedge clk) begin
		body_state_t e, a;
		if (m_tvalid && m_tready) begin
			a.pos_x = m_tdata[31:0];
			a.pos_y = m_tdata[63:32];
			a.vel_x = m_tdata[95:64];
			a.vel_y = m_tdata[127:96];
			a.speed = m_tdata[159:128];
			a.heading = m_tdata[175:160];
			a.bounced = m_tdata[177:176];
			if (expected_bodies.size() == 0) begin
				$error("result word with no tick outstanding");
				mismatches++;
			end else begin
				e = expected_bodies.pop_front();
				ticks_checked++;
				if (a.pos_x !== e.pos_x) begin
					$error("position_x exp %h got %h", e.pos_x, a.pos_x); mismatches++;
				end
				if (a.pos_y !== e.pos_y) begin
					$error("position_y exp %h got %h", e.pos_y, a.pos_y); mismatches++;
				end
				if (a.vel_x !== e.vel_x) begin
					$error("velocity_x exp %h got %h", e.vel_x, a.vel_x); mismatches++;
				end
				if (a.vel_y !== e.vel_y) begin
					$error("velocity_y exp %h got %h", e.vel_y, a.vel_y); mismatches++;
				end
				if (a.speed !== e.speed) begin
					$error("speed_magnitude exp %h got %h", e.speed, a.speed); mismatches++;
				end
				if (a.heading !== e.heading) begin
					$error("heading exp %h got %h", e.heading, a.heading); mismatches++;
				end
				if (a.bounced !== e.bounced) begin
					$error("bounced exp %b got %b", e.bounced, a.bounced); mismatches++;
				end
			end
		end
	end

	initial begin
		drag_k = 0; density = 65536; thrust_acc = 0; inv_mass = 65536;
		wall_x = VMAX; wall_y = VMAX;
		body_px = 0; body_py = 0; body_vx = 0; body_vy = 0; body_heading = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		test_defaults();
		test_thrust_keys();
		test_drag();
		test_walls();
		test_backpressure();
		test_random();
		$display("Covered %0d ticks (%0d checked): keys, force and step extremes, drag,",
			ticks_sent, ticks_checked);
		$display("wall mirroring, heading updates, six register settings and a long stall.");
		if (mismatches == 0 && expected_bodies.size() == 0)
			$display("tb_drag_thrust_body_step passed");
		else
			$display("tb_drag_thrust_body_step failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("tb_drag_thrust_body_step failed");
		$finish;
	end
endmodule

// File: drag_thrust_body_step.f
rtl/dts_pkg.sv
rtl/dts_mul.sv
rtl/dts_sqrt.sv
rtl/dts_cordic.sv
rtl/drag_thrust_body_step.sv
tb/tb_drag_thrust_body_step.sv
